// ===== rtl/cpi_pkg.sv =====
// Shared widths for the color palette indexer.
`timescale 1ns / 1ps
`default_nettype none

package cpi_pkg;

  localparam int COLOR_W = 32;
  localparam int IDX_W   = 10;
  localparam int CNT_W   = 11;

endpackage

`default_nettype wire

// ===== rtl/cpi_palette_ram.sv =====
// Palette store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module cpi_palette_ram #(
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [cpi_pkg::COLOR_W-1:0] wr_data,
  input  wire logic                        rd_en,
  input  wire logic [AW-1:0]               rd_addr,
  output logic      [cpi_pkg::COLOR_W-1:0] rd_data
);

  logic [cpi_pkg::COLOR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/color_palette_indexer.sv =====
// Top level: palette lookup-or-insert sequencer around the palette store.
//
// An item is taken when start is high and busy is low. The stored palette
// is searched from entry 0 upward, one memory read per cycle through the
// single read port of the palette store. A pixel that matches entry k keeps
// busy high while entries 0 to k are read; an unmatched pixel against a
// palette of n entries keeps it high while all n are read, and a pixel that
// opens a new image (or meets an empty palette) never raises it. Its result
// appears on the out_ ports for one cycle, marked by out_valid, in the first
// cycle with busy low again (the cycle after acceptance when busy never
// rose), and the next item may be started in that same cycle. The receiver
// cannot stall the block, so every result beat must be taken when shown.
`timescale 1ns / 1ps
`default_nettype none

module color_palette_indexer #(
  parameter int MAX_COLORS = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [cpi_pkg::COLOR_W-1:0] in_pixel_color,
  input  wire logic                        in_new_image,
  output logic                             out_valid,
  output logic      [cpi_pkg::IDX_W-1:0]   out_color_index,
  output logic                             out_was_added,
  output logic                             out_overflow,
  output logic      [cpi_pkg::CNT_W-1:0]   out_color_count
);

  localparam int AW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
  localparam int CW = $clog2(MAX_COLORS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_COLORS);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t                      state_r, state_nxt;
  logic [cpi_pkg::COLOR_W-1:0] color_r, color_nxt;
  logic [AW-1:0]               scan_r, scan_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [cpi_pkg::IDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic                        out_added_r, out_added_nxt;
  logic                        out_over_r, out_over_nxt;
  logic [cpi_pkg::CNT_W-1:0]   out_cnt_r, out_cnt_nxt;

  logic                        accept;
  logic [CW-1:0]               cnt_eff;
  logic [CW-1:0]               scan_next_k;
  logic                        ins_req;
  logic [CW-1:0]               ins_cnt;
  logic [cpi_pkg::COLOR_W-1:0] ins_color;

  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [cpi_pkg::COLOR_W-1:0] rd_data;

  assign busy        = (state_r == S_SCAN);
  assign accept      = start && !busy;
  assign cnt_eff     = in_new_image ? '0 : cnt_r;
  assign scan_next_k = CW'(scan_r) + CW'(1);

  cpi_palette_ram #(
    .DEPTH(MAX_COLORS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (ins_color),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    color_nxt     = color_r;
    scan_nxt      = scan_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_idx_nxt   = out_idx_r;
    out_added_nxt = out_added_r;
    out_over_nxt  = out_over_r;
    out_cnt_nxt   = out_cnt_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    ins_req       = 1'b0;
    ins_cnt       = cnt_r;
    ins_color     = color_r;
    wr_en         = 1'b0;
    wr_addr       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          color_nxt = in_pixel_color;
          cnt_nxt   = cnt_eff;
          if (cnt_eff == '0) begin
            ins_req   = 1'b1;
            ins_cnt   = '0;
            ins_color = in_pixel_color;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = '0;
            scan_nxt  = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_data == color_r) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = cpi_pkg::IDX_W'(scan_r);
          out_added_nxt = 1'b0;
          out_over_nxt  = 1'b0;
          out_cnt_nxt   = cpi_pkg::CNT_W'(cnt_r);
          state_nxt     = S_IDLE;
        end else if (scan_next_k == cnt_r) begin
          ins_req   = 1'b1;
          ins_cnt   = cnt_r;
          state_nxt = S_IDLE;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = scan_next_k[AW-1:0];
          scan_nxt = scan_next_k[AW-1:0];
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (ins_req) begin
      out_valid_nxt = 1'b1;
      if (ins_cnt < MAX_CNT) begin
        wr_en         = 1'b1;
        wr_addr       = ins_cnt[AW-1:0];
        cnt_nxt       = ins_cnt + CW'(1);
        out_idx_nxt   = cpi_pkg::IDX_W'(ins_cnt);
        out_added_nxt = 1'b1;
        out_over_nxt  = 1'b0;
        out_cnt_nxt   = cpi_pkg::CNT_W'(ins_cnt + CW'(1));
      end else begin
        out_idx_nxt   = '0;
        out_added_nxt = 1'b0;
        out_over_nxt  = 1'b1;
        out_cnt_nxt   = cpi_pkg::CNT_W'(ins_cnt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    color_r     <= color_nxt;
    scan_r      <= scan_nxt;
    out_idx_r   <= out_idx_nxt;
    out_added_r <= out_added_nxt;
    out_over_r  <= out_over_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_color_index = out_idx_r;
  assign out_was_added   = out_added_r;
  assign out_overflow    = out_over_r;
  assign out_color_count = out_cnt_r;

endmodule

`default_nettype wire
